// ===== hdl/reed_solomon_parity_encoder_unit_macros.svh =====
// Assertion helpers for the encoder core.
// Each expects i_clk and i_rst_n in the scope where it is used.
`ifndef REED_SOLOMON_PARITY_ENCODER_UNIT_MACROS_SVH
`define REED_SOLOMON_PARITY_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define RSPE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RSPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rspe_pkg.sv =====
package rspe_pkg;

    localparam int MAX_SYMBOL_BITS = 8;
    localparam int MAX_PARITY      = 64;
    localparam int FIELD_SIZE      = 1 << MAX_SYMBOL_BITS;
    localparam int GEN_DEPTH       = MAX_PARITY + 1;

    localparam logic [3:0] RST_SYMBOL_BITS  = 4'd8;
    localparam logic [8:0] RST_FIELD_POLY   = 9'd285;
    localparam logic [7:0] RST_FIRST_ROOT   = 8'd0;
    localparam logic [7:0] RST_ROOT_STEP    = 8'd1;
    localparam logic [6:0] RST_PARITY_COUNT = 7'd32;
    localparam logic [7:0] RST_PAD_COUNT    = 8'd0;

    typedef struct packed {
        logic [3:0] symbol_bits;
        logic [8:0] field_poly;
        logic [7:0] first_root;
        logic [7:0] root_step;
        logic [6:0] parity_count;
        logic [7:0] pad_count;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_SYMBOL_BITS  = 3'd0,
        REG_FIELD_POLY   = 3'd1,
        REG_FIRST_ROOT   = 3'd2,
        REG_ROOT_STEP    = 3'd3,
        REG_PARITY_COUNT = 3'd4,
        REG_PAD_COUNT    = 3'd5
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_FLD,
        S_ROOT,
        S_GONE,
        S_GRD,
        S_GAL,
        S_GWR,
        S_LRD,
        S_LLG,
        S_LWR,
        S_DISPATCH,
        S_CK0,
        S_CK1,
        S_CK2,
        S_CKL,
        S_AFTER,
        S_ERR,
        S_ERD,
        S_EOUT
    } t_state;

endpackage

// ===== hdl/rspe_core.sv =====
`include "reed_solomon_parity_encoder_unit_macros.svh"

module rspe_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rspe_pkg::t_cfg    i_cfg,
    input  logic              i_cfg_wr,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_data_symbol,
    input  logic              i_last_symbol,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_parity_symbol,
    output logic              o_last_parity,
    output logic              o_config_error
);

    function automatic logic [7:0] f_addmod(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] nn);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, nn}) begin
            s = s - {1'b0, nn};
        end
        return s[7:0];
    endfunction

    // Tables and division register
    logic [7:0] m_alog [rspe_pkg::FIELD_SIZE];
    logic [7:0] m_log  [rspe_pkg::FIELD_SIZE];
    logic [7:0] m_gen  [rspe_pkg::GEN_DEPTH];
    logic [7:0] m_par  [rspe_pkg::MAX_PARITY];
    logic [rspe_pkg::MAX_PARITY-1:0] r_par_v;

    logic       alog_we, log_we, gen_we, par_we, par_clr;
    logic [7:0] alog_wa, alog_wd, alog_ra, log_wa, log_wd, log_ra, gen_wd, par_wd;
    logic [6:0] gen_wa, gen_ra;
    logic [5:0] par_wa, par_ra;
    logic [7:0] r_alog_q, r_log_q, r_gen_q, r_par_q;
    logic       r_par_vq;

    rspe_pkg::t_state r_state, n_state;
    logic       r_tables_ready, n_tables_ready;
    logic       r_cfg_bad, n_cfg_bad;
    logic [7:0] r_count, n_count;
    logic [7:0] r_sym, n_sym;
    logic       r_last, n_last;
    logic [6:0] r_i, n_i;
    logic [6:0] r_j, n_j;
    logic [7:0] r_cnt, n_cnt;
    logic [7:0] r_sr, n_sr;
    logic [7:0] r_root, n_root;
    logic [7:0] r_cur, n_cur;
    logic [7:0] r_gprev, n_gprev;
    logic [7:0] r_fb, n_fb;
    logic       r_p1_v, n_p1_v;
    logic [6:0] r_p1_j, n_p1_j;
    logic       r_p2_v, n_p2_v;
    logic [6:0] r_p2_j, n_p2_j;
    logic [7:0] r_p2_par, n_p2_par;
    logic       r_p2_ok, n_p2_ok;
    logic       r_ov;
    logic [7:0] r_op;
    logic       r_ol, r_oe;

    logic       out_load, out_last, out_err;
    logic [7:0] out_par;
    logic       slot_free;

    logic [7:0] nn, np8, k, step_eff, par_eff, sr_next;
    logic [6:0] np7;
    logic [8:0] s9;
    logic       cfg_ok;

    assign nn       = 8'((16'd1 << i_cfg.symbol_bits) - 16'd1);
    assign np7      = i_cfg.parity_count;
    assign np8      = {1'b0, np7};
    assign k        = nn - np8 - i_cfg.pad_count;
    assign step_eff = (i_cfg.root_step == nn) ? 8'd0 : i_cfg.root_step;
    assign par_eff  = r_par_vq ? r_par_q : 8'd0;
    assign cfg_ok   = (i_cfg.symbol_bits >= 4'd2)
                   && (i_cfg.symbol_bits <= 4'(rspe_pkg::MAX_SYMBOL_BITS))
                   && (i_cfg.first_root <= nn)
                   && (i_cfg.root_step != 8'd0) && (i_cfg.root_step <= nn)
                   && (np7 != 7'd0) && (np7 <= 7'(rspe_pkg::MAX_PARITY))
                   && (np8 < nn) && (i_cfg.pad_count < (nn - np8));

    // Multiply by x modulo the field polynomial
    always_comb begin
        s9 = {r_sr, 1'b0};
        if (s9[i_cfg.symbol_bits]) begin
            s9 = s9 ^ i_cfg.field_poly;
        end
        sr_next = s9[7:0] & nn;
    end

    assign slot_free  = !r_ov || i_out_ready;
    assign o_in_ready = (r_state == rspe_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;       n_tables_ready = r_tables_ready; n_cfg_bad = r_cfg_bad;
        n_count = r_count;       n_sym = r_sym;     n_last = r_last;
        n_i = r_i;   n_j = r_j;  n_cnt = r_cnt;     n_sr = r_sr;     n_root = r_root;
        n_cur = r_cur;           n_gprev = r_gprev; n_fb = r_fb;
        n_p1_v = 1'b0;           n_p1_j = r_p1_j;
        n_p2_v = 1'b0;           n_p2_j = r_p2_j;   n_p2_par = r_p2_par; n_p2_ok = r_p2_ok;
        alog_we = 1'b0; alog_wa = '0; alog_wd = '0; alog_ra = '0;
        log_we  = 1'b0; log_wa  = '0; log_wd  = '0; log_ra  = '0;
        gen_we  = 1'b0; gen_wa  = '0; gen_wd  = '0; gen_ra  = '0;
        par_we  = 1'b0; par_wa  = '0; par_wd  = '0; par_ra  = '0;
        par_clr = 1'b0;
        out_load = 1'b0; out_par = '0; out_last = 1'b0; out_err = 1'b0;

        case (r_state)
            rspe_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_sym  = i_data_symbol;
                    n_last = i_last_symbol;
                    n_state = r_tables_ready ? rspe_pkg::S_DISPATCH : rspe_pkg::S_CHECK;
                end
            end
            rspe_pkg::S_CHECK: begin
                n_tables_ready = 1'b1;
                par_clr = 1'b1;
                n_count = '0;
                if (!cfg_ok) begin
                    n_cfg_bad = 1'b1;
                    n_state = rspe_pkg::S_DISPATCH;
                end else begin
                    log_we = 1'b1;  log_wa = '0;  log_wd = nn;
                    alog_we = 1'b1; alog_wa = nn; alog_wd = '0;
                    n_sr = 8'd1;
                    n_cnt = '0;
                    n_state = rspe_pkg::S_FLD;
                end
            end
            rspe_pkg::S_FLD: begin
                // an early return to one means the polynomial is not primitive
                if (r_cnt != 8'd0 && r_sr == 8'd1) begin
                    n_cfg_bad = 1'b1;
                    n_state = rspe_pkg::S_DISPATCH;
                end else begin
                    log_we = 1'b1;  log_wa = r_sr & nn; log_wd = r_cnt;
                    alog_we = 1'b1; alog_wa = r_cnt;    alog_wd = r_sr;
                    n_sr = sr_next;
                    n_cnt = r_cnt + 8'd1;
                    if (r_cnt == nn - 8'd1) begin
                        if (sr_next != 8'd1) begin
                            n_cfg_bad = 1'b1;
                            n_state = rspe_pkg::S_DISPATCH;
                        end else begin
                            n_cnt = '0;
                            n_root = '0;
                            n_state = rspe_pkg::S_ROOT;
                        end
                    end
                end
            end
            rspe_pkg::S_ROOT: begin
                // first root exponent by repeated addition of the step
                if (r_cnt != i_cfg.first_root) begin
                    n_root = f_addmod(r_root, step_eff, nn);
                    n_cnt = r_cnt + 8'd1;
                end else begin
                    gen_we = 1'b1; gen_wa = '0; gen_wd = 8'd1;
                    n_i = '0;
                    n_state = rspe_pkg::S_GONE;
                end
            end
            rspe_pkg::S_GONE: begin
                gen_we = 1'b1; gen_wa = r_i + 7'd1; gen_wd = 8'd1;
                n_j = r_i;
                n_cur = 8'd1;
                n_state = rspe_pkg::S_GRD;
            end
            rspe_pkg::S_GRD: begin
                gen_ra = r_j - 7'd1;
                log_ra = r_cur;
                n_state = rspe_pkg::S_GAL;
            end
            rspe_pkg::S_GAL: begin
                n_gprev = (r_j == 7'd0) ? 8'd0 : r_gen_q;
                alog_ra = f_addmod(r_log_q, r_root, nn);
                n_state = rspe_pkg::S_GWR;
            end
            rspe_pkg::S_GWR: begin
                gen_we = 1'b1; gen_wa = r_j;
                gen_wd = (r_cur != 8'd0) ? (r_gprev ^ r_alog_q) : r_gprev;
                n_cur = r_gprev;
                if (r_j == 7'd0) begin
                    n_root = f_addmod(r_root, step_eff, nn);
                    n_i = r_i + 7'd1;
                    if (r_i == np7 - 7'd1) begin
                        n_j = '0;
                        n_state = rspe_pkg::S_LRD;
                    end else begin
                        n_state = rspe_pkg::S_GONE;
                    end
                end else begin
                    n_j = r_j - 7'd1;
                    n_state = rspe_pkg::S_GRD;
                end
            end
            rspe_pkg::S_LRD: begin
                gen_ra = r_j;
                n_state = rspe_pkg::S_LLG;
            end
            rspe_pkg::S_LLG: begin
                log_ra = r_gen_q;
                n_state = rspe_pkg::S_LWR;
            end
            rspe_pkg::S_LWR: begin
                // coefficients are kept in log form
                gen_we = 1'b1; gen_wa = r_j; gen_wd = r_log_q;
                if (r_j == np7) begin
                    n_cfg_bad = 1'b0;
                    n_state = rspe_pkg::S_DISPATCH;
                end else begin
                    n_j = r_j + 7'd1;
                    n_state = rspe_pkg::S_LRD;
                end
            end
            rspe_pkg::S_DISPATCH: begin
                n_sym = r_sym & nn;
                if (r_cfg_bad) begin
                    n_state = rspe_pkg::S_ERR;
                end else if (r_count < k) begin
                    n_state = rspe_pkg::S_CK0;
                end else begin
                    n_state = rspe_pkg::S_AFTER;
                end
            end
            rspe_pkg::S_CK0: begin
                par_ra = '0;
                n_state = rspe_pkg::S_CK1;
            end
            rspe_pkg::S_CK1: begin
                log_ra = (par_eff ^ r_sym) & nn;
                n_state = rspe_pkg::S_CK2;
            end
            rspe_pkg::S_CK2: begin
                n_fb = r_log_q;
                n_j = 7'd1;
                n_state = rspe_pkg::S_CKL;
            end
            rspe_pkg::S_CKL: begin
                // issue: read stage j and coefficient np-j
                if (r_j <= np7) begin
                    par_ra = r_j[5:0];
                    gen_ra = np7 - r_j;
                    n_p1_v = 1'b1;
                    n_p1_j = r_j;
                    n_j = r_j + 7'd1;
                end
                // look up the product term
                if (r_p1_v) begin
                    alog_ra = f_addmod(r_fb, r_gen_q, nn);
                    n_p2_v = 1'b1;
                    n_p2_j = r_p1_j;
                    n_p2_par = (r_p1_j == np7) ? 8'd0 : par_eff;
                    n_p2_ok = (r_fb != nn) && (r_gen_q != nn);
                end
                // shift down by one while adding the term
                if (r_p2_v) begin
                    par_we = 1'b1;
                    par_wa = 6'(r_p2_j - 7'd1);
                    par_wd = r_p2_par ^ (r_p2_ok ? r_alog_q : 8'd0);
                    if (r_p2_j == np7) begin
                        n_count = r_count + 8'd1;
                        n_p1_v = 1'b0;
                        n_p2_v = 1'b0;
                        n_state = rspe_pkg::S_AFTER;
                    end
                end
            end
            rspe_pkg::S_AFTER: begin
                if (!r_last) begin
                    n_state = rspe_pkg::S_IDLE;
                end else if (r_count < k) begin
                    n_sym = '0;
                    n_state = rspe_pkg::S_CK0;
                end else begin
                    n_j = '0;
                    n_state = rspe_pkg::S_ERD;
                end
            end
            rspe_pkg::S_ERR: begin
                if (slot_free) begin
                    out_load = 1'b1; out_par = '0; out_last = 1'b1; out_err = 1'b1;
                    n_state = rspe_pkg::S_IDLE;
                end
            end
            rspe_pkg::S_ERD: begin
                par_ra = r_j[5:0];
                n_state = rspe_pkg::S_EOUT;
            end
            rspe_pkg::S_EOUT: begin
                par_ra = r_j[5:0];
                if (slot_free) begin
                    out_load = 1'b1;
                    out_par = par_eff;
                    out_last = (r_j == np7 - 7'd1);
                    if (r_j == np7 - 7'd1) begin
                        par_clr = 1'b1;
                        n_count = '0;
                        n_state = rspe_pkg::S_IDLE;
                    end else begin
                        n_j = r_j + 7'd1;
                        n_state = rspe_pkg::S_ERD;
                    end
                end
            end
            default: begin
                n_state = rspe_pkg::S_IDLE;
            end
        endcase

        // a register write drops the tables and the codeword in progress
        if (i_cfg_wr) begin
            n_tables_ready = 1'b0;
            n_count = '0;
            par_clr = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rspe_pkg::S_IDLE;
            r_tables_ready <= 1'b0;
            r_cfg_bad <= 1'b0;
            r_count <= '0;
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tables_ready <= n_tables_ready;
            r_cfg_bad <= n_cfg_bad;
            r_count <= n_count;
            r_p1_v <= n_p1_v;
            r_p2_v <= n_p2_v;
            r_ov <= (r_ov && !i_out_ready) || out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;     r_last <= n_last;
        r_i <= n_i;         r_j <= n_j;       r_cnt <= n_cnt;
        r_sr <= n_sr;       r_root <= n_root; r_cur <= n_cur;
        r_gprev <= n_gprev; r_fb <= n_fb;
        r_p1_j <= n_p1_j;   r_p2_j <= n_p2_j; r_p2_par <= n_p2_par; r_p2_ok <= n_p2_ok;
        if (out_load) begin
            r_op <= out_par;
            r_ol <= out_last;
            r_oe <= out_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (alog_we) begin
            m_alog[alog_wa] <= alog_wd;
        end
        r_alog_q <= m_alog[alog_ra];
    end

    always_ff @(posedge i_clk) begin
        if (log_we) begin
            m_log[log_wa] <= log_wd;
        end
        r_log_q <= m_log[log_ra];
    end

    always_ff @(posedge i_clk) begin
        if (gen_we) begin
            m_gen[gen_wa] <= gen_wd;
        end
        r_gen_q <= m_gen[gen_ra];
    end

    always_ff @(posedge i_clk) begin
        if (par_we) begin
            m_par[par_wa] <= par_wd;
        end
        r_par_q  <= m_par[par_ra];
        r_par_vq <= r_par_v[par_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par_v <= '0;
        end else if (par_clr) begin
            r_par_v <= '0;
        end else if (par_we) begin
            r_par_v[par_wa] <= 1'b1;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_parity_symbol = r_op;
    assign o_last_parity   = r_ol;
    assign o_config_error  = r_oe;

    `RSPE_ASSERT_IMP(a_err_result_form, r_ov && r_oe, r_ol && (r_op == 8'd0), "error result not a lone zero")
    `RSPE_ASSERT_NEXT(a_cfg_wr_drops_state, i_cfg_wr, !r_tables_ready && (r_count == 8'd0) && (r_par_v == '0), "register write left stale state")
    `RSPE_ASSERT_IMP(a_stage_index_range, r_p2_v, (r_p2_j != 7'd0) && (r_p2_j <= i_cfg.parity_count), "division stage index out of range")

endmodule

// ===== hdl/reed_solomon_parity_encoder_unit.sv =====
// Channel   Handshake                  Payload
// in        i_in_valid / o_in_ready    i_data_symbol, i_last_symbol
// out       o_out_valid / i_out_ready  o_parity_symbol, o_last_parity, o_config_error
// config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A request whose symbol enters the division register does one table lookup per
// register stage (np = parity_count) through the shared add-mod and antilog path.
// A last request also shifts in zero padding for the (k - count) missing data
// symbols, then reads out the np parity symbols; output stalls hold the read-out.
// The first request after reset or a register write first builds the tables.
// Reset is synchronous, active low; it restores the register defaults.
module reed_solomon_parity_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_symbol,
    input  logic        i_last_symbol,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_parity_symbol,
    output logic        o_last_parity,
    output logic        o_config_error
);

    rspe_pkg::t_cfg     r_cfg;
    rspe_pkg::t_reg_idx reg_idx;
    logic               wr_req;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = rspe_pkg::t_reg_idx'(paddr[4:2]);
    assign wr_req  = psel && penable && pwrite;

    always_comb begin
        cfg_wr = 1'b0;
        prdata = '0;
        case (reg_idx)
            rspe_pkg::REG_SYMBOL_BITS: begin
                cfg_wr = wr_req;
                prdata = 32'(r_cfg.symbol_bits);
            end
            rspe_pkg::REG_FIELD_POLY: begin
                cfg_wr = wr_req;
                prdata = 32'(r_cfg.field_poly);
            end
            rspe_pkg::REG_FIRST_ROOT: begin
                cfg_wr = wr_req;
                prdata = 32'(r_cfg.first_root);
            end
            rspe_pkg::REG_ROOT_STEP: begin
                cfg_wr = wr_req;
                prdata = 32'(r_cfg.root_step);
            end
            rspe_pkg::REG_PARITY_COUNT: begin
                cfg_wr = wr_req;
                prdata = 32'(r_cfg.parity_count);
            end
            rspe_pkg::REG_PAD_COUNT: begin
                cfg_wr = wr_req;
                prdata = 32'(r_cfg.pad_count);
            end
            default: begin
                cfg_wr = 1'b0;
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.symbol_bits  <= rspe_pkg::RST_SYMBOL_BITS;
            r_cfg.field_poly   <= rspe_pkg::RST_FIELD_POLY;
            r_cfg.first_root   <= rspe_pkg::RST_FIRST_ROOT;
            r_cfg.root_step    <= rspe_pkg::RST_ROOT_STEP;
            r_cfg.parity_count <= rspe_pkg::RST_PARITY_COUNT;
            r_cfg.pad_count    <= rspe_pkg::RST_PAD_COUNT;
        end else if (wr_req) begin
            case (reg_idx)
                rspe_pkg::REG_SYMBOL_BITS:  r_cfg.symbol_bits  <= pwdata[3:0];
                rspe_pkg::REG_FIELD_POLY:   r_cfg.field_poly   <= pwdata[8:0];
                rspe_pkg::REG_FIRST_ROOT:   r_cfg.first_root   <= pwdata[7:0];
                rspe_pkg::REG_ROOT_STEP:    r_cfg.root_step    <= pwdata[7:0];
                rspe_pkg::REG_PARITY_COUNT: r_cfg.parity_count <= pwdata[6:0];
                rspe_pkg::REG_PAD_COUNT:    r_cfg.pad_count    <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    rspe_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cfg_wr        (cfg_wr),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_symbol   (i_data_symbol),
        .i_last_symbol   (i_last_symbol),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_parity_symbol (o_parity_symbol),
        .o_last_parity   (o_last_parity),
        .o_config_error  (o_config_error)
    );

endmodule

// ===== bench/rspe_checker.sv =====
module rspe_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_data_symbol,
    input  logic        i_last_symbol,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_parity_symbol,
    input  logic        i_last_parity,
    input  logic        i_config_error,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] symbol;
        logic       last;
        logic       error;
    } t_parity_word;

    t_parity_word parity_q[$];

    logic [3:0] cfg_bits;
    logic [8:0] cfg_poly;
    logic [7:0] cfg_first;
    logic [7:0] cfg_step;
    logic [6:0] cfg_np;
    logic [7:0] cfg_pad;

    logic [7:0] antilog[rspe_pkg::FIELD_SIZE];
    logic [7:0] logs[rspe_pkg::FIELD_SIZE];
    logic [7:0] gen_logs[rspe_pkg::GEN_DEPTH];
    logic [7:0] division[rspe_pkg::MAX_PARITY];
    int         symbols_in;
    bit         field_built;
    bit         field_bad;

    function automatic void clear_codeword();
        for (int i = 0; i < rspe_pkg::MAX_PARITY; i++) division[i] = '0;
        symbols_in = 0;
    endfunction

    // Build log/antilog tables and generator logs; return 0 on a bad setting.
    function automatic bit build_field();
        int m, nn, np, sr, root;
        int g[rspe_pkg::GEN_DEPTH];
        m = cfg_bits;
        if (m < 2 || m > rspe_pkg::MAX_SYMBOL_BITS) return 1'b0;
        nn = (1 << m) - 1;
        np = cfg_np;
        if (cfg_first > nn) return 1'b0;
        if (cfg_step < 1 || cfg_step > nn) return 1'b0;
        if (np < 1 || np > rspe_pkg::MAX_PARITY || np >= nn) return 1'b0;
        if (cfg_pad >= nn - np) return 1'b0;
        logs[0] = nn[7:0];
        antilog[nn] = '0;
        sr = 1;
        for (int i = 0; i < nn; i++) begin
            if (i > 0 && sr == 1) return 1'b0;
            logs[sr & nn] = i[7:0];
            antilog[i] = sr[7:0];
            sr = sr << 1;
            if (sr & (1 << m)) sr = sr ^ cfg_poly;
            sr = sr & nn;
        end
        if (sr != 1) return 1'b0;
        g[0] = 1;
        for (int i = 0; i < np; i++) begin
            root = ((cfg_first + i) * cfg_step) % nn;
            g[i + 1] = 1;
            for (int j = i; j > 0; j--) begin
                if (g[j] != 0)
                    g[j] = g[j - 1] ^ antilog[(logs[g[j] & nn] + root) % nn];
                else
                    g[j] = g[j - 1];
            end
            g[0] = antilog[(logs[g[0] & nn] + root) % nn];
        end
        for (int i = 0; i <= np; i++) gen_logs[i] = logs[g[i] & nn];
        return 1'b1;
    endfunction

    function automatic void shift_symbol(int sym);
        int nn, np, fb, gl;
        nn = (1 << cfg_bits) - 1;
        np = cfg_np;
        fb = logs[(sym ^ division[0]) & nn];
        if (fb != nn) begin
            for (int j = 1; j < np; j++) begin
                gl = gen_logs[np - j];
                if (gl != nn) division[j] = division[j] ^ antilog[(fb + gl) % nn];
            end
        end
        for (int j = 0; j + 1 < np; j++) division[j] = division[j + 1];
        if (fb != nn && gen_logs[0] != nn)
            division[np - 1] = antilog[(fb + gen_logs[0]) % nn];
        else
            division[np - 1] = '0;
    endfunction

    function automatic void encode_request(logic [7:0] sym, logic last);
        int nn, np, k;
        t_parity_word w;
        if (!field_built) begin
            field_bad = !build_field();
            field_built = 1'b1;
            clear_codeword();
        end
        if (field_bad) begin
            w.symbol = '0;
            w.last = 1'b1;
            w.error = 1'b1;
            parity_q.push_back(w);
            return;
        end
        nn = (1 << cfg_bits) - 1;
        np = cfg_np;
        k = nn - np - cfg_pad;
        if (symbols_in < k) begin
            shift_symbol(sym & nn);
            symbols_in++;
        end
        if (!last) return;
        // pad the missing data positions with zeros
        while (symbols_in < k) begin
            shift_symbol(0);
            symbols_in++;
        end
        for (int j = 0; j < np; j++) begin
            w.symbol = division[j];
            w.last = (j + 1 == np);
            w.error = 1'b0;
            parity_q.push_back(w);
        end
        clear_codeword();
    endfunction

    always @(posedge i_clk) begin
        t_parity_word w;
        if (!i_rst_n) begin
            cfg_bits = rspe_pkg::RST_SYMBOL_BITS;
            cfg_poly = rspe_pkg::RST_FIELD_POLY;
            cfg_first = rspe_pkg::RST_FIRST_ROOT;
            cfg_step = rspe_pkg::RST_ROOT_STEP;
            cfg_np = rspe_pkg::RST_PARITY_COUNT;
            cfg_pad = rspe_pkg::RST_PAD_COUNT;
            field_built = 1'b0;
            field_bad = 1'b0;
            clear_codeword();
            parity_q.delete();
            o_fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[4:2] <= rspe_pkg::REG_PAD_COUNT) begin
                    case (rspe_pkg::t_reg_idx'(paddr[4:2]))
                        rspe_pkg::REG_SYMBOL_BITS:  cfg_bits = pwdata[3:0];
                        rspe_pkg::REG_FIELD_POLY:   cfg_poly = pwdata[8:0];
                        rspe_pkg::REG_FIRST_ROOT:   cfg_first = pwdata[7:0];
                        rspe_pkg::REG_ROOT_STEP:    cfg_step = pwdata[7:0];
                        rspe_pkg::REG_PARITY_COUNT: cfg_np = pwdata[6:0];
                        rspe_pkg::REG_PAD_COUNT:    cfg_pad = pwdata[7:0];
                        default: ;
                    endcase
                    field_built = 1'b0;
                    clear_codeword();
                end
            end
            if (i_in_valid && i_in_ready) encode_request(i_data_symbol, i_last_symbol);
            if (i_out_valid && i_out_ready) begin
                if (parity_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t unexpected parity %h last %b err %b", $time,
                                 i_parity_symbol, i_last_parity, i_config_error);
                end else begin
                    w = parity_q.pop_front();
                    if (w.symbol !== i_parity_symbol || w.last !== i_last_parity ||
                        w.error !== i_config_error) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t parity mismatch: exp %h/%b/%b got %h/%b/%b",
                                     $time, w.symbol, w.last, w.error, i_parity_symbol,
                                     i_last_parity, i_config_error);
                    end
                end
            end
        end
        o_pending = parity_q.size();
    end

endmodule

// ===== bench/reed_solomon_parity_encoder_unit_tb.sv =====
module reed_solomon_parity_encoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_REGS = 6;
    localparam int SETTLE_CYCLES = 200;
    localparam int TARGET_REQUESTS = 430;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_symbol;
    logic        i_last_symbol;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_parity_symbol;
    logic        o_last_parity;
    logic        o_config_error;

    int fail_count;
    int pending;
    int sent;
    bit calm;

    reed_solomon_parity_encoder_unit dut (.*);

    rspe_checker checker_i (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .i_in_valid, .i_in_ready(o_in_ready), .i_data_symbol, .i_last_symbol,
        .i_out_valid(o_out_valid), .i_out_ready, .i_parity_symbol(o_parity_symbol),
        .i_last_parity(o_last_parity), .i_config_error(o_config_error),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: unless calm, stall for a random time before each parity symbol.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 4);
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    task automatic send_symbol(input logic [7:0] sym, input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_symbol <= sym;
        i_last_symbol <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
    endtask

    task automatic send_codeword(input int len);
        for (int i = 0; i < len; i++)
            send_symbol(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    // Hold the sender until every parity symbol is out, then let the block settle.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input int idx, input int value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 5'(idx * 4);
        pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_field(input int m, input int poly, input int first, input int step,
                             input int np, input int pad);
        drain();
        write_reg(rspe_pkg::REG_SYMBOL_BITS, m);
        write_reg(rspe_pkg::REG_FIELD_POLY, poly);
        write_reg(rspe_pkg::REG_FIRST_ROOT, first);
        write_reg(rspe_pkg::REG_ROOT_STEP, step);
        write_reg(rspe_pkg::REG_PARITY_COUNT, np);
        write_reg(rspe_pkg::REG_PAD_COUNT, pad);
    endtask

    function automatic int primitive_poly(input int m, input bit alt);
        case (m)
            2: return 7;
            3: return alt ? 13 : 11;
            4: return alt ? 25 : 19;
            5: return alt ? 41 : 37;
            6: return 67;
            7: return 137;
            default: return alt ? 301 : 285;
        endcase
    endfunction

    initial begin
        int m, nn, np, kk, pad, r, words;
        bit raw;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_data_symbol = '0;
        i_last_symbol = 1'b0;
        sent = 0;
        calm = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, a short codeword padded out to full length
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'h5A, 1'b1);
        // smallest field, one parity, excess symbols ignored
        set_field(2, 7, 0, 1, 1, 0);
        send_symbol(8'h03, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'hAA, 1'b0);
        send_symbol(8'h01, 1'b1);
        // widest setting: 64 parity symbols, maximum roots, heavy shortening
        set_field(8, 285, 255, 255, 64, 190);
        send_symbol(8'hFF, 1'b1);
        send_symbol(8'h80, 1'b0);
        send_symbol(8'h7F, 1'b1);
        // write to an unused address leaves the codeword intact
        set_field(4, 25, 15, 15, 14, 0);
        send_symbol(8'h0F, 1'b0);
        write_reg(NUM_REGS, 3);
        send_symbol(8'hF0, 1'b1);
        // polynomials that do not generate the field
        set_field(4, 31, 0, 1, 4, 0);
        send_symbol(8'h12, 1'b0);
        send_symbol(8'h34, 1'b1);
        set_field(8, 511, 0, 1, 4, 0);
        send_symbol(8'h55, 1'b1);
        set_field(4, 0, 0, 1, 4, 0);
        send_symbol(8'h55, 1'b1);
        // out-of-range settings, then one in range at the upper bounds
        set_field(0, 7, 0, 1, 1, 0);
        send_symbol(8'h01, 1'b1);
        set_field(15, 285, 0, 1, 4, 0);
        send_symbol(8'h02, 1'b1);
        set_field(3, 11, 8, 0, 127, 254);
        send_symbol(8'h03, 1'b0);
        set_field(3, 11, 7, 7, 2, 4);
        send_symbol(8'h04, 1'b1);

        while (sent < TARGET_REQUESTS) begin
            raw = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 9);
            m = (r == 0) ? 2 : (r == 1) ? 3 : (r < 5) ? 4 : (r < 8) ? r : 8;
            nn = (1 << m) - 1;
            np = $urandom_range(1, (nn - 1 < rspe_pkg::MAX_PARITY) ? nn - 1
                                                                   : rspe_pkg::MAX_PARITY);
            kk = $urandom_range(1, (nn - np < 12) ? nn - np : 12);
            pad = nn - np - kk;
            if (raw) begin
                set_field($urandom_range(0, 15), $urandom_range(0, 511),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 127), $urandom_range(0, 255));
                kk = 2;
            end else begin
                set_field(m, primitive_poly(m, $urandom_range(0, 1)), $urandom_range(0, nn),
                          $urandom_range(1, nn), np, pad);
            end
            calm = ($urandom_range(0, 3) == 0);
            words = $urandom_range(1, 5);
            for (int w = 0; w < words; w++) send_codeword($urandom_range(1, kk + 2));
        end

        drain();
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/rspe_pkg.sv
hdl/rspe_core.sv
hdl/reed_solomon_parity_encoder_unit.sv
bench/rspe_checker.sv
bench/reed_solomon_parity_encoder_unit_tb.sv
